### hdl/psr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

    localparam int HASH_W  = 64;
    localparam int START_W = 64;
    localparam int SEQ_W   = 32;

    localparam int S_TDATA_W = HASH_W + START_W + SEQ_W;
    localparam int M_TDATA_W = SEQ_W;

    // all ones doubles as the "no packet seen yet" marker
    localparam logic [SEQ_W-1:0] NONE_YET = '1;

    typedef enum logic [2:0] {
        DISP_CURRENT  = 3'd0,
        DISP_HELD_OUT = 3'd1,
        DISP_HELD     = 3'd2,
        DISP_OLD      = 3'd3,
        DISP_HELD_DUP = 3'd4,
        DISP_HASH     = 3'd5,
        DISP_OLDER    = 3'd6,
        DISP_BAD_HDR  = 3'd7
    } disp_t;

    typedef struct packed {
        disp_t            disp;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } res_t;

endpackage

`default_nettype wire

### hdl/packet_sequence_reorder_one.sv
`timescale 1ns / 1ps
`default_nettype none

// Packet sequence reorder, one packet deep.
// s_* carries one received packet header per transaction; m_* carries one or
// two results per header (slot sequence number in m_tdata, disposition in
// m_tuser, m_tlast on the final result of a header). cfg_* writes the
// expected configuration hash; it is always ready and is meant to be written
// only while no header is in flight.
// A header is registered on acceptance and classified against the tracker
// state from the input register; its first result is loaded into the output
// register, which drives m_tvalid. A second result waits in a one-entry stage
// behind the output register.
// Throughput: one header per cycle while m_tready stays high and each header
// releases one result; a header that releases both the current and the held
// packet stalls the next one until its second result leaves the second-result stage.
// While the receiver holds m_tready low, the output register keeps its
// result, one further header may wait in the input register and s_tready
// drops only then.
// Reset (rst_n low, asynchronous) clears the hash to zero, the newest sender
// start to zero, the last sequence number to all ones, empties the held slot
// and drops any header or result in flight.
module packet_sequence_reorder_one
    import psr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [HASH_W-1:0]    cfg_data,    // expected_hash

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // packet_hash, sender_start, packet_seq
    input  wire logic                 s_tuser,     // header_ok

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,     // slot_seq
    output logic [2:0]                m_tuser,     // disposition
    output logic                      m_tlast      // last_of_run
);

    logic [HASH_W-1:0]    hash_cfg_reg;

    logic                 in_vld_reg;
    logic                 in_ok_reg;
    logic [HASH_W-1:0]    in_hash_reg;
    logic [START_W-1:0]   in_start_reg;
    logic [SEQ_W-1:0]     in_seq_reg;

    logic [START_W-1:0]   newest_reg, newest_next;
    logic [SEQ_W-1:0]     last_seq_reg, last_seq_next;
    logic                 holding_reg, holding_next;
    logic [SEQ_W-1:0]     held_seq_reg, held_seq_next;

    logic                 a_vld_reg;
    res_t                 a_res_reg;
    logic                 b_vld_reg;
    res_t                 b_res_reg;

    res_t                 r0, r1;
    logic                 two;
    logic                 fire;
    logic                 start_gt, start_lt;
    logic [SEQ_W-1:0]     base_last;
    logic [SEQ_W-1:0]     diff;
    logic [SEQ_W-1:0]     expected_seq;

    assign cfg_ready = 1'b1;

    // process a header once the second-result stage is free and the output
    // register is empty or being emptied
    assign fire     = in_vld_reg && !b_vld_reg && (!a_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    assign m_tvalid = a_vld_reg;
    assign m_tdata  = a_res_reg.seq;
    assign m_tuser  = a_res_reg.disp;
    assign m_tlast  = a_res_reg.last;

    assign start_gt     = in_start_reg > newest_reg;
    assign start_lt     = in_start_reg < newest_reg;
    assign base_last    = start_gt ? NONE_YET : last_seq_reg;
    assign diff         = in_seq_reg - base_last;
    assign expected_seq = base_last + SEQ_W'(1);

    always_comb
    begin
        r0            = '{disp: DISP_CURRENT, seq: in_seq_reg, last: 1'b1};
        r1            = '{disp: DISP_HELD_OUT, seq: held_seq_reg, last: 1'b1};
        two           = 1'b0;
        newest_next   = newest_reg;
        last_seq_next = last_seq_reg;
        holding_next  = holding_reg;
        held_seq_next = held_seq_reg;

        if (!in_ok_reg)
        begin
            r0.disp = DISP_BAD_HDR;
        end
        else if (in_hash_reg != hash_cfg_reg)
        begin
            r0.disp = DISP_HASH;
        end
        else if (start_lt)
        begin
            r0.disp = DISP_OLDER;
        end
        else
        begin
            if (start_gt)
            begin
                newest_next   = in_start_reg;
                last_seq_next = NONE_YET;
            end

            if (base_last == NONE_YET)
            begin
                last_seq_next = in_seq_reg;
            end
            else if (diff == '0 || diff[SEQ_W-1])
            begin
                r0.disp = DISP_OLD;
            end
            else if (in_seq_reg == expected_seq)
            begin
                if (holding_reg)
                begin
                    r0.last       = 1'b0;
                    two           = 1'b1;
                    last_seq_next = held_seq_reg;
                    holding_next  = 1'b0;
                end
                else
                begin
                    last_seq_next = in_seq_reg;
                end
            end
            else if (in_seq_reg == expected_seq + SEQ_W'(1) && !holding_reg)
            begin
                r0.disp       = DISP_HELD;
                holding_next  = 1'b1;
                held_seq_next = in_seq_reg;
            end
            else if (holding_reg && in_seq_reg == held_seq_reg)
            begin
                r0.disp = DISP_HELD_DUP;
            end
            else
            begin
                // gap: flush the held packet ahead of the current one
                last_seq_next = in_seq_reg;
                if (holding_reg)
                begin
                    holding_next = 1'b0;
                    two          = 1'b1;
                    r0           = '{disp: DISP_HELD_OUT, seq: held_seq_reg, last: 1'b0};
                    r1           = '{disp: DISP_CURRENT, seq: in_seq_reg, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_cfg_reg <= '0;
            in_vld_reg   <= 1'b0;
            newest_reg   <= '0;
            last_seq_reg <= NONE_YET;
            holding_reg  <= 1'b0;
            held_seq_reg <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                hash_cfg_reg <= cfg_data;
            end

            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end

            if (fire)
            begin
                newest_reg   <= newest_next;
                last_seq_reg <= last_seq_next;
                holding_reg  <= holding_next;
                held_seq_reg <= held_seq_next;
                a_vld_reg    <= 1'b1;
                b_vld_reg    <= two;
            end
            else if (a_vld_reg && m_tready)
            begin
                a_vld_reg <= b_vld_reg;
                b_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ok_reg    <= s_tuser;
            in_hash_reg  <= s_tdata[HASH_W-1:0];
            in_start_reg <= s_tdata[HASH_W +: START_W];
            in_seq_reg   <= s_tdata[HASH_W+START_W +: SEQ_W];
        end

        if (fire)
        begin
            a_res_reg <= r0;
            b_res_reg <= r1;
        end
        else if (a_vld_reg && m_tready && b_vld_reg)
        begin
            a_res_reg <= b_res_reg;
        end
    end

    // a waiting second result always sits behind a first one of the same header
    a_b_behind_a: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |-> a_vld_reg && !a_res_reg.last)
        else $error("second result stage filled without a leading first result");

    a_b_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |-> b_res_reg.last)
        else $error("second result of a header is not marked last");

    a_two_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && two |-> holding_reg && !holding_next)
        else $error("two results released without a held packet");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && r0.disp == DISP_HELD |=> holding_reg && held_seq_reg == a_res_reg.seq)
        else $error("held disposition without the packet being held");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg && !m_tready && !b_vld_reg |=> a_vld_reg)
        else $error("stalled result lost");

endmodule

`default_nettype wire

### bench/tb_packet_sequence_reorder_one.sv
`timescale 1ns / 1ps

module tb_packet_sequence_reorder_one;
    import psr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // tracks the reorder window and holds the results still owed by the block
    class reorder_scoreboard;
        logic [HASH_W-1:0]  hash_reg;
        logic [START_W-1:0] newest_start;
        logic [SEQ_W-1:0]   last_seq;
        bit                 holding;
        logic [SEQ_W-1:0]   held_seq;
        res_t               releases_due[$];
        int                 errors;

        function new();
            hash_reg     = '0;
            newest_start = '0;
            last_seq     = NONE_YET;
            holding      = 1'b0;
            held_seq     = '0;
            errors       = 0;
        endfunction

        function void set_hash(logic [HASH_W-1:0] value);
            hash_reg = value;
        endfunction

        function void owe(disp_t disp, logic [SEQ_W-1:0] seq, logic last);
            res_t r;
            r.disp = disp;
            r.seq  = seq;
            r.last = last;
            releases_due.push_back(r);
        endfunction

        // work out the release(s) caused by one accepted header
        function void classify_header(logic ok, logic [HASH_W-1:0] hash,
                                      logic [START_W-1:0] start, logic [SEQ_W-1:0] seq);
            logic [SEQ_W-1:0] diff;
            diff = '0;
            if (!ok)
                owe(DISP_BAD_HDR, seq, 1'b1);
            else if (hash != hash_reg)
                owe(DISP_HASH, seq, 1'b1);
            else if (start < newest_start)
                owe(DISP_OLDER, seq, 1'b1);
            else
            begin
                if (start > newest_start)
                begin
                    newest_start = start;
                    last_seq     = NONE_YET;
                end
                if (last_seq == NONE_YET)
                begin
                    last_seq = seq;
                    owe(DISP_CURRENT, seq, 1'b1);
                end
                else
                begin
                    diff = seq - last_seq;
                    if (diff == '0 || diff[SEQ_W-1])
                        owe(DISP_OLD, seq, 1'b1);
                    else if (seq == last_seq + 32'd1)
                    begin
                        if (holding)
                        begin
                            owe(DISP_CURRENT, seq, 1'b0);
                            owe(DISP_HELD_OUT, held_seq, 1'b1);
                            last_seq = held_seq;
                            holding  = 1'b0;
                        end
                        else
                        begin
                            owe(DISP_CURRENT, seq, 1'b1);
                            last_seq = seq;
                        end
                    end
                    else if (seq == last_seq + 32'd2 && !holding)
                    begin
                        holding  = 1'b1;
                        held_seq = seq;
                        owe(DISP_HELD, seq, 1'b1);
                    end
                    else if (holding && seq == held_seq)
                        owe(DISP_HELD_DUP, seq, 1'b1);
                    else
                    begin
                        // gap: flush the held packet first
                        last_seq = seq;
                        if (holding)
                        begin
                            holding = 1'b0;
                            owe(DISP_HELD_OUT, held_seq, 1'b0);
                            owe(DISP_CURRENT, seq, 1'b1);
                        end
                        else
                            owe(DISP_CURRENT, seq, 1'b1);
                    end
                end
            end
        endfunction

        function void check_release(logic [2:0] disp, logic [SEQ_W-1:0] seq, logic last);
            res_t want;
            if (releases_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result disp=%0d seq=%h last=%0d",
                         $time, disp, seq, last);
            end
            else
            begin
                want = releases_due.pop_front();
                if (want.disp != disp || want.seq != seq || want.last != last)
                begin
                    errors++;
                    $display("%0t: expected disp=%0d seq=%h last=%0d, got disp=%0d seq=%h last=%0d",
                             $time, want.disp, want.seq, want.last, disp, seq, last);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [HASH_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;     // packet_hash, sender_start, packet_seq
    logic                 s_tuser = 1'b0;   // header_ok
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // slot_seq
    logic [2:0]           m_tuser;          // disposition
    logic                 m_tlast;          // last_of_run

    int send_stall = 0;
    int recv_stall = 0;
    int cycle_count = 0;

    reorder_scoreboard sb = new();

    packet_sequence_reorder_one DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("packet_sequence_reorder_one: mismatch");
            $finish;
        end
    end

    // receiving side: check each result and pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_release(m_tuser, m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_header(input logic ok, input logic [HASH_W-1:0] hash,
                               input logic [START_W-1:0] start, input logic [SEQ_W-1:0] seq);
        while ($urandom_range(99) < send_stall)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seq, start, hash};
        s_tuser  <= ok;
        do
            @(posedge clk);
        while (!s_tready);
        sb.classify_header(ok, hash, start, seq);
    endtask

    // hold off the sender until every owed result has come back
    task automatic drain_releases();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.releases_due.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_hash(input logic [HASH_W-1:0] value);
        drain_releases();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_hash(value);
        cfg_valid <= 1'b0;
    endtask

    // next number for the current sender: mostly in order, some holds, gaps and stale ones
    function automatic logic [SEQ_W-1:0] stream_seq();
        int pick;
        logic [SEQ_W-1:0] last;
        pick = $urandom_range(99);
        last = sb.last_seq;
        if (last == NONE_YET)
            return ($urandom_range(3) == 0) ? NONE_YET - $urandom_range(0, 3) : $urandom;
        if (pick < 40)
            return last + 32'd1;
        if (pick < 55)
            return last + 32'd2;
        if (pick < 65)
            return sb.holding ? sb.held_seq : last + 32'd1;
        if (pick < 77)
            return last + $urandom_range(3, 20);
        if (pick < 85)
            return last - $urandom_range(0, 20);
        if (pick < 93)
            return last + 32'h7fff_ffff + $urandom_range(0, 1);
        return $urandom;
    endfunction

    task automatic random_headers(input int count);
        int i;
        int kind;
        logic ok;
        logic [HASH_W-1:0] hash;
        logic [START_W-1:0] start;
        logic [SEQ_W-1:0] seq;
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(149) == 0)
                drain_releases();
            kind  = $urandom_range(99);
            ok    = 1'b1;
            hash  = sb.hash_reg;
            start = sb.newest_start;
            seq   = stream_seq();
            if (kind < 4)
            begin
                ok    = 1'($urandom_range(1));
                hash  = {$urandom, $urandom};
                start = {$urandom, $urandom};
                seq   = $urandom;
            end
            else if (kind < 7)
                ok = 1'b0;
            else if (kind < 10)
                hash = hash ^ (64'd1 << $urandom_range(HASH_W - 1));
            else if (kind < 12)
                start = start >> $urandom_range(1, 8);
            else if (kind < 16)
            begin
                // sender restart, now and then right below the wrap point
                if (start[START_W-1:START_W-4] != 0)
                    start = start + 64'($urandom_range(1, 1000));
                else
                    start = start + 64'd1 + ({32'd0, $urandom} << $urandom_range(0, 28));
                seq = ($urandom_range(2) == 0) ? NONE_YET - $urandom_range(0, 4) : $urandom;
            end
            send_header(ok, hash, start, seq);
        end
    endtask

    task automatic directed_headers();
        logic [HASH_W-1:0] h;
        h = sb.hash_reg;
        send_header(1'b0, '1, '1, '1);
        send_header(1'b1, ~h, '1, 32'd0);
        send_header(1'b1, h, 64'd5, 32'd100);
        send_header(1'b1, h, 64'd4, 32'd101);
        send_header(1'b1, h, 64'd5, 32'd101);
        send_header(1'b1, h, 64'd5, 32'd101);
        send_header(1'b1, h, 64'd5, 32'd50);
        send_header(1'b1, h, 64'd5, 32'd103);
        send_header(1'b1, h, 64'd5, 32'd103);
        send_header(1'b1, h, 64'd5, 32'd102);
        send_header(1'b1, h, 64'd5, 32'd105);
        send_header(1'b1, h, 64'd5, 32'd110);
        send_header(1'b1, h, 64'd5, 32'd112);
        // restart while a packet is held, then release it in order
        send_header(1'b1, h, 64'd9, 32'd500);
        send_header(1'b1, h, 64'd9, 32'd501);
        // running into the all-ones number brings back the first-packet case
        send_header(1'b1, h, 64'd20, 32'hffff_fffe);
        send_header(1'b1, h, 64'd20, 32'hffff_ffff);
        send_header(1'b1, h, 64'd20, 32'd7);
        send_header(1'b1, h, 64'd20, 32'h8000_0006);
        send_header(1'b1, h, 64'd20, 32'd6);
        send_header(1'b1, h, 64'd30, 32'hffff_fffd);
        send_header(1'b1, h, 64'd30, 32'hffff_ffff);
        send_header(1'b1, h, 64'd30, 32'hffff_fffe);
        send_header(1'b1, h, 64'd30, 32'd3);
        send_header(1'b0, h, 64'd30, 32'd4);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_stall = 19;
        recv_stall = 75;
        write_hash('0);
        directed_headers();
        random_headers(430);

        send_stall = 75;
        recv_stall = 19;
        write_hash('1);
        random_headers(430);

        send_stall = 0;
        recv_stall = 0;
        write_hash({$urandom, $urandom});
        random_headers(430);

        drain_releases();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.releases_due.size() == 0)
            $display("packet_sequence_reorder_one: match");
        else
            $display("packet_sequence_reorder_one: mismatch");
        $finish;
    end

endmodule
